// ===== hdl/lfrg_pkg.sv =====
// Shared constants, request codes and controller/datapath interface structs
// for the lagged Fibonacci range generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfrg_pkg;

  // Lag table geometry.
  localparam int unsigned TableLength = 55;
  localparam int unsigned ShortLag    = 24;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned WordW       = 30;
  localparam int unsigned DrawShift   = 6;
  localparam int unsigned DrawW       = WordW - DrawShift;

  // Request and result field widths.
  localparam int unsigned OpW    = 2;
  localparam int unsigned FieldW = 24;
  localparam int unsigned ValueW = 25;

  localparam logic [IdxW-1:0]   PartnerStart = IdxW'(TableLength - ShortLag);
  localparam logic [IdxW-1:0]   LastIdx      = IdxW'(TableLength - 1);
  localparam logic [IdxW-1:0]   LagDistance  = IdxW'(ShortLag);
  localparam logic [ValueW-1:0] SumLimit     = ValueW'(24'hFF_FFFF);
  localparam logic [WordW-1:0]  SeedReset    = WordW'(1);

  // Request operations.
  typedef enum logic [OpW-1:0] {
    OP_RANGE = 2'd0,
    OP_BITS  = 2'd1,
    OP_FUZZY = 2'd2,
    OP_DICE  = 2'd3
  } op_e;

  // Commands from the controller to the datapath and the lag table.
  typedef struct packed {
    logic capture;
    logic setup;
    logic build;
    logic read;
    logic add;
    logic eval;
    logic finish;
  } cmd_t;

  // Status from the lag table.
  typedef struct packed {
    logic table_ready;
    logic build_last;
  } tbl_status_t;

  // Status from the request datapath.
  typedef struct packed {
    logic need_draw;
    logic draw_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lfrg_table.sv =====
// Lag table unit: 55 x 30-bit memory, seed register, table build sweep and
// the draw read-modify-write. Depends on lfrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrg_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           seed_we_i,
  input  logic [lfrg_pkg::WordW-1:0]     seed_i,
  input  lfrg_pkg::cmd_t                 cmd_i,
  output lfrg_pkg::tbl_status_t          status_o,
  output logic [lfrg_pkg::DrawW-1:0]     draw_o
);

  logic [lfrg_pkg::WordW-1:0] mem_q [lfrg_pkg::TableLength];

  logic [lfrg_pkg::WordW-1:0] seed_q, seed_d;
  logic                       ready_q, ready_d;
  logic [lfrg_pkg::IdxW-1:0]  bidx_q, bidx_d;
  logic [lfrg_pkg::IdxW-1:0]  wi_q, wi_d;
  logic [lfrg_pkg::IdxW-1:0]  pi_q, pi_d;

  logic [lfrg_pkg::WordW-1:0] p1_q, p2_q;
  logic [lfrg_pkg::WordW-1:0] rd_a_q, rd_b_q;
  logic [lfrg_pkg::DrawW-1:0] draw_q;

  logic                       build_last;
  logic [lfrg_pkg::WordW-1:0] build_word;
  logic [lfrg_pkg::WordW-1:0] sum;
  logic                       wr_en;
  logic [lfrg_pkg::IdxW-1:0]  wr_addr;
  logic [lfrg_pkg::WordW-1:0] wr_data;

  // Build word: the seed, then one, then the sum of the two previous words.
  always_comb begin
    build_last = (bidx_q == lfrg_pkg::LastIdx);
    priority if (bidx_q == '0) begin
      build_word = seed_q;
    end else if (bidx_q == lfrg_pkg::IdxW'(1)) begin
      build_word = lfrg_pkg::WordW'(1);
    end else begin
      build_word = p1_q + p2_q;
    end
    sum = rd_a_q + rd_b_q;
  end

  // Single write port shared by the build sweep and the draw write-back.
  always_comb begin
    wr_en   = cmd_i.build | cmd_i.add;
    wr_addr = cmd_i.build ? bidx_q : wi_q;
    wr_data = cmd_i.build ? build_word : sum;
  end

  // Control state: seed, table status and indices.
  always_comb begin
    seed_d  = seed_q;
    ready_d = ready_q;
    bidx_d  = bidx_q;
    wi_d    = wi_q;
    pi_d    = pi_q;
    if (seed_we_i) begin
      seed_d  = seed_i;
      ready_d = 1'b0;
    end
    if (cmd_i.build) begin
      bidx_d = build_last ? '0 : bidx_q + lfrg_pkg::IdxW'(1);
      if (build_last) begin
        ready_d = 1'b1;
        wi_d    = '0;
        pi_d    = lfrg_pkg::PartnerStart;
      end
    end
    if (cmd_i.add) begin
      wi_d = (wi_q == lfrg_pkg::LastIdx) ? '0 : wi_q + lfrg_pkg::IdxW'(1);
      pi_d = (pi_q == lfrg_pkg::LastIdx) ? '0 : pi_q + lfrg_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= lfrg_pkg::SeedReset;
      ready_q <= 1'b0;
      bidx_q  <= '0;
      wi_q    <= '0;
      pi_q    <= lfrg_pkg::PartnerStart;
    end else begin
      seed_q  <= seed_d;
      ready_q <= ready_d;
      bidx_q  <= bidx_d;
      wi_q    <= wi_d;
      pi_q    <= pi_d;
    end
  end

  // Memory with registered reads, plus the build history and draw registers.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.read) begin
      rd_a_q <= mem_q[wi_q];
      rd_b_q <= mem_q[pi_q];
    end
    if (cmd_i.build) begin
      p2_q <= p1_q;
      p1_q <= build_word;
    end
    if (cmd_i.add) begin
      draw_q <= sum[lfrg_pkg::WordW-1:lfrg_pkg::DrawShift];
    end
  end

  assign status_o.table_ready = ready_q;
  assign status_o.build_last  = build_last;
  assign draw_o               = draw_q;

  // The partner index always trails the write index by the short lag.
  a_lag_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pi_q == wi_q + lfrg_pkg::PartnerStart) || (wi_q == pi_q + lfrg_pkg::LagDistance))
    else $error("lag table indices lost their distance");

  // A write-back always uses the words fetched in the cycle before.
  a_add_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add |-> $past(cmd_i.read))
    else $error("table write-back without a preceding read");

endmodule

`default_nettype wire

// ===== hdl/lfrg_dp.sv =====
// Request datapath: captures a request, decodes bounds and masks, evaluates
// draws and holds the result register. Depends on lfrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrg_dp #(
  parameter int unsigned MaxDice = 255
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfrg_pkg::cmd_t                    cmd_i,
  input  logic [lfrg_pkg::OpW-1:0]          operation_i,
  input  logic signed [lfrg_pkg::FieldW-1:0] first_value_i,
  input  logic signed [lfrg_pkg::FieldW-1:0] second_value_i,
  input  logic [lfrg_pkg::DrawW-1:0]        draw_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [lfrg_pkg::ValueW-1:0] value_o,
  output lfrg_pkg::dp_status_t              status_o
);

  localparam int unsigned CountW = $clog2(MaxDice + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MaxDice);
  localparam int unsigned DiffW = lfrg_pkg::ValueW + 1;

  // Fill every bit below the leading one.
  function automatic logic [lfrg_pkg::DrawW-1:0] smear(input logic [lfrg_pkg::DrawW-1:0] d);
    logic [lfrg_pkg::DrawW-1:0] m;
    m = d;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    m = m | (m >> 16);
    return m;
  endfunction

  lfrg_pkg::op_e                      op_q;
  logic signed [lfrg_pkg::FieldW-1:0] a_q, b_q;
  logic signed [lfrg_pkg::ValueW-1:0] base_q;
  logic [lfrg_pkg::DrawW-1:0]         diff_q;
  logic [lfrg_pkg::DrawW-1:0]         mask_q;
  logic [CountW-1:0]                  rolls_q, rolls_d;
  logic [lfrg_pkg::ValueW-1:0]        acc_q, acc_d;
  logic                               out_valid_q, out_valid_d;
  logic [lfrg_pkg::ValueW-1:0]        value_q;

  logic signed [lfrg_pkg::ValueW-1:0] lo_s, hi_s;
  logic signed [DiffW-1:0]            diff_s;
  logic                               count_pos, count_big, span_pos;
  logic [CountW-1:0]                  rolls_init;
  logic [lfrg_pkg::DrawW-1:0]         bits_mask;
  logic [lfrg_pkg::DrawW-1:0]         mask_init;
  logic [lfrg_pkg::ValueW-1:0]        acc_init;
  logic                               need_draw;

  logic [lfrg_pkg::DrawW-1:0]         n;
  logic                               hit;
  logic signed [lfrg_pkg::ValueW-1:0] fuzz, fuzz_res, range_res;
  logic [DiffW-1:0]                   dice_sum;
  logic [lfrg_pkg::ValueW-1:0]        dice_res;
  logic                               draw_done;
  logic                               out_free;

  // Request decode: bounds, span, masks and the result of requests that draw nothing.
  always_comb begin
    lo_s = (op_q == lfrg_pkg::OP_DICE) ? lfrg_pkg::ValueW'(1) : {a_q[lfrg_pkg::FieldW-1], a_q};
    hi_s = {b_q[lfrg_pkg::FieldW-1], b_q};
    diff_s = {hi_s[lfrg_pkg::ValueW-1], hi_s} - {lo_s[lfrg_pkg::ValueW-1], lo_s};
    span_pos  = !diff_s[DiffW-1] && (diff_s != '0);
    count_pos = !a_q[lfrg_pkg::FieldW-1] && (a_q != '0);
    count_big = a_q > $signed(lfrg_pkg::FieldW'(MaxDice));
    rolls_init = count_big ? CountMax : a_q[CountW-1:0];

    // Bit-width mask: empty for a non-positive width, whole draw from 24 up.
    priority if (a_q[lfrg_pkg::FieldW-1] || (a_q == '0)) begin
      bits_mask = '0;
    end else if (a_q >= $signed(lfrg_pkg::FieldW'(lfrg_pkg::DrawW))) begin
      bits_mask = '1;
    end else begin
      bits_mask = ~({lfrg_pkg::DrawW{1'b1}} << a_q[4:0]);
    end

    mask_init = (op_q == lfrg_pkg::OP_BITS) ? bits_mask
                                            : (smear(diff_s[lfrg_pkg::DrawW-1:0]) |
                                               lfrg_pkg::DrawW'(1));

    unique case (op_q)
      lfrg_pkg::OP_RANGE: begin
        acc_init = lo_s;
      end
      lfrg_pkg::OP_DICE: begin
        // One-sided dice return the count; negative sides count one per roll.
        priority if (b_q == lfrg_pkg::FieldW'(1)) begin
          acc_init = {a_q[lfrg_pkg::FieldW-1], a_q};
        end else if (b_q[lfrg_pkg::FieldW-1] && count_pos) begin
          acc_init = lfrg_pkg::ValueW'(rolls_init);
        end else begin
          acc_init = '0;
        end
      end
      default: begin
        acc_init = '0;
      end
    endcase

    unique case (op_q)
      lfrg_pkg::OP_RANGE: need_draw = span_pos;
      lfrg_pkg::OP_DICE:  need_draw = span_pos && count_pos;
      default:            need_draw = 1'b1;
    endcase
  end

  // Draw evaluation: masked value, rejection test, fuzz and dice accumulation.
  always_comb begin
    n         = draw_i & mask_q;
    hit       = (n <= diff_q);
    range_res = base_q + $signed({1'b0, n});
    unique case (draw_i[1:0])
      2'b00:   fuzz = base_q - lfrg_pkg::ValueW'(1);
      2'b11:   fuzz = base_q + lfrg_pkg::ValueW'(1);
      default: fuzz = base_q;
    endcase
    fuzz_res = (fuzz[lfrg_pkg::ValueW-1] || (fuzz == '0)) ? lfrg_pkg::ValueW'(1) : fuzz;
    dice_sum = {1'b0, acc_q} + DiffW'(n) + DiffW'(1);
    dice_res = (dice_sum > DiffW'(lfrg_pkg::SumLimit)) ? lfrg_pkg::SumLimit
                                                       : dice_sum[lfrg_pkg::ValueW-1:0];
    unique case (op_q)
      lfrg_pkg::OP_RANGE: draw_done = hit;
      lfrg_pkg::OP_DICE:  draw_done = hit && (rolls_q == CountW'(1));
      default:            draw_done = 1'b1;
    endcase
  end

  // Accumulator and roll counter.
  always_comb begin
    acc_d   = acc_q;
    rolls_d = rolls_q;
    if (cmd_i.setup) begin
      acc_d   = acc_init;
      rolls_d = rolls_init;
    end else if (cmd_i.eval) begin
      unique case (op_q)
        lfrg_pkg::OP_RANGE: begin
          if (hit) begin
            acc_d = range_res;
          end
        end
        lfrg_pkg::OP_BITS: begin
          acc_d = lfrg_pkg::ValueW'(n);
        end
        lfrg_pkg::OP_FUZZY: begin
          acc_d = fuzz_res;
        end
        lfrg_pkg::OP_DICE: begin
          if (hit) begin
            acc_d   = dice_res;
            rolls_d = rolls_q - CountW'(1);
          end
        end
      endcase
    end
  end

  // Request capture and per-request decode registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= lfrg_pkg::op_e'(operation_i);
      a_q  <= first_value_i;
      b_q  <= second_value_i;
    end
    if (cmd_i.setup) begin
      base_q <= lo_s;
      diff_q <= diff_s[lfrg_pkg::DrawW-1:0];
      mask_q <= mask_init;
    end
    acc_q   <= acc_d;
    rolls_q <= rolls_d;
    if (cmd_i.finish) begin
      value_q <= acc_q;
    end
  end

  // Output register: a finished result waits here while the next request runs.
  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign value_o            = value_q;
  assign status_o.need_draw = need_draw;
  assign status_o.draw_done = draw_done;
  assign status_o.out_free  = out_free;

  // A dice draw is only evaluated while rolls remain.
  a_rolls_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && (op_q == lfrg_pkg::OP_DICE)) |-> (rolls_q != '0))
    else $error("dice draw evaluated with no rolls left");

endmodule

`default_nettype wire

// ===== hdl/lfrg_ctrl.sv =====
// Controller state machine: sequences capture, decode, table build, draws
// and result hand-over. Depends on lfrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lfrg_pkg::tbl_status_t tbl_status_i,
  input  lfrg_pkg::dp_status_t  dp_status_i,
  output lfrg_pkg::cmd_t        cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_SETUP  = 7'b000_0010,
    S_BUILD  = 7'b000_0100,
    S_READ   = 7'b000_1000,
    S_ADD    = 7'b001_0000,
    S_EVAL   = 7'b010_0000,
    S_FINISH = 7'b100_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        priority if (!dp_status_i.need_draw) begin
          state_d = S_FINISH;
        end else if (!tbl_status_i.table_ready) begin
          state_d = S_BUILD;
        end else begin
          state_d = S_READ;
        end
      end
      S_BUILD: begin
        cmd_o.build = 1'b1;
        if (tbl_status_i.build_last) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = dp_status_i.draw_done ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        if (dp_status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Only one request is in flight at a time.
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  // The lag table is never read before it has been built.
  a_read_built: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read |-> tbl_status_i.table_ready)
    else $error("lag table read before build");

endmodule

`default_nettype wire

// ===== hdl/lagged_fibonacci_range_generator_core.sv =====
// Lagged Fibonacci range generator top level; instantiates lfrg_ctrl, lfrg_dp, lfrg_table.
// A request passes through capture, setup and finish when no draw is made; each draw adds a table read,
// an add and write-back, and an evaluation; range rejections and dice rolls add draws.
// The next request enters while a result waits.
// The first draw after reset or a seed write first runs a table build sweep.
// Reset clears the control state and sets the seed to 1; the table is rebuilt on demand.
`timescale 1ns / 1ps
`default_nettype none

module lagged_fibonacci_range_generator_core #(
  parameter int unsigned MaxDice = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               seed_we_i,
  input  logic [lfrg_pkg::WordW-1:0]         seed_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lfrg_pkg::OpW-1:0]           operation_i,
  input  logic signed [lfrg_pkg::FieldW-1:0] first_value_i,
  input  logic signed [lfrg_pkg::FieldW-1:0] second_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lfrg_pkg::ValueW-1:0] value_o
);

  lfrg_pkg::cmd_t             cmd;
  lfrg_pkg::tbl_status_t      tbl_status;
  lfrg_pkg::dp_status_t       dp_status;
  logic [lfrg_pkg::DrawW-1:0] draw;

  // Request sequencer.
  lfrg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tbl_status_i (tbl_status),
    .dp_status_i  (dp_status),
    .cmd_o        (cmd)
  );

  // Lag table and draw generation.
  lfrg_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (seed_we_i),
    .seed_i    (seed_i),
    .cmd_i     (cmd),
    .status_o  (tbl_status),
    .draw_o    (draw)
  );

  // Request decode, draw evaluation and result register.
  lfrg_dp #(
    .MaxDice (MaxDice)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .draw_i         (draw),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .value_o        (value_o),
    .status_o       (dp_status)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_lagged_fibonacci_range_generator_core.sv =====
// Self-checking testbench for lagged_fibonacci_range_generator_core.
// Drives range, bits, fuzzy and dice requests and predicts every result with a
// bit-accurate lag table model. Depends on lfrg_pkg and the core.
`timescale 1ns / 1ps

module tb_lagged_fibonacci_range_generator_core;
  import lfrg_pkg::*;

  localparam int unsigned DiceLimit     = 255;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned MismatchShown = 10;
  localparam int unsigned SegmentItems  = 92;
  localparam longint      DiceSumLimit  = 16777215;

  typedef struct {
    op_e                      op;
    logic signed [FieldW-1:0] first_value;
    logic signed [FieldW-1:0] second_value;
  } lfrg_request_t;

  // Block ports; the inputs are driven to known values from time zero.
  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      seed_we_i      = 1'b0;
  logic [WordW-1:0]          seed_i         = '0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic [OpW-1:0]            operation_i    = '0;
  logic signed [FieldW-1:0]  first_value_i  = '0;
  logic signed [FieldW-1:0]  second_value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic signed [ValueW-1:0]  value_o;

  // Request traffic and checking state.
  lfrg_request_t     pending_requests[$];
  logic [ValueW-1:0] expected_values[$];
  logic              req_taken = 1'b0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       quiet_cycles = 0;

  // Predictor state: seed register and the lag table with its two pointers.
  logic [WordW-1:0]  seed_value = SeedReset;
  logic [WordW-1:0]  lag_words [TableLength];
  int unsigned       lag_write_pos = 0;
  int unsigned       lag_partner_pos = TableLength - ShortLag;
  bit                lag_built = 1'b0;

  lagged_fibonacci_range_generator_core #(
    .MaxDice(DiceLimit)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .seed_we_i     (seed_we_i),
    .seed_i        (seed_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .first_value_i (first_value_i),
    .second_value_i(second_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o)
  );

  always #4 clk_i = ~clk_i;

  // Fill the lag table from the seed: a Fibonacci sequence modulo 2^30.
  function automatic void build_lag_words();
    int i;
    lag_words[0] = seed_value;
    lag_words[1] = WordW'(1);
    for (i = 2; i < TableLength; i++) begin
      lag_words[i] = lag_words[i-1] + lag_words[i-2];
    end
    lag_write_pos   = 0;
    lag_partner_pos = TableLength - ShortLag;
    lag_built       = 1'b1;
  endfunction

  // One generator step: add the lagged pair, write back, return the top 24 bits.
  function automatic logic [DrawW-1:0] next_draw();
    logic [WordW-1:0] sum;
    if (!lag_built) begin
      build_lag_words();
    end
    sum = lag_words[lag_write_pos] + lag_words[lag_partner_pos];
    lag_words[lag_write_pos] = sum;
    lag_write_pos   = (lag_write_pos == TableLength - 1) ? 0 : lag_write_pos + 1;
    lag_partner_pos = (lag_partner_pos == TableLength - 1) ? 0 : lag_partner_pos + 1;
    return sum[WordW-1:DrawShift];
  endfunction

  // Uniform pick in lo..hi by power-of-two masking with rejection.
  function automatic longint pick_in_span(input longint lo, input longint hi);
    longint span;
    longint power;
    longint n;
    if (lo == 0 && hi == 0) begin
      return 0;
    end
    span = hi - lo + 1;
    if (span <= 1) begin
      return lo;
    end
    power = 2;
    while (power < span) begin
      power = power * 2;
    end
    do begin
      n = longint'(next_draw()) & (power - 1);
    end while (n >= span);
    return lo + n;
  endfunction

  // Expected result of one request; advances the predictor state.
  function automatic logic [ValueW-1:0] predict_value(input op_e op,
                                                      input logic signed [FieldW-1:0] first,
                                                      input logic signed [FieldW-1:0] second);
    longint a;
    longint b;
    longint r;
    longint rolls;
    longint i;
    logic [DrawW-1:0] d;
    a = longint'(first);
    b = longint'(second);
    r = 0;
    case (op)
      OP_RANGE: begin
        r = pick_in_span(a, b);
      end
      OP_BITS: begin
        d = next_draw();
        if (a <= 0) begin
          r = 0;
        end else if (a >= DrawW) begin
          r = longint'(d);
        end else begin
          r = longint'(d) & ((longint'(1) << a) - 1);
        end
      end
      OP_FUZZY: begin
        d = next_draw();
        r = a;
        if (d[1:0] == 2'd0) begin
          r = r - 1;
        end else if (d[1:0] == 2'd3) begin
          r = r + 1;
        end
        if (r < 1) begin
          r = 1;
        end
      end
      default: begin
        // Dice: zero sides and one side short-circuit before the count is clamped.
        if (b == 0) begin
          r = 0;
        end else if (b == 1) begin
          r = a;
        end else begin
          rolls = (a > longint'(DiceLimit)) ? longint'(DiceLimit) : a;
          for (i = 0; i < rolls; i++) begin
            r = r + pick_in_span(1, b);
            if (r > DiceSumLimit) begin
              r = DiceSumLimit;
            end
          end
        end
      end
    endcase
    return r[ValueW-1:0];
  endfunction

  // Random request, weighted towards cheap and well-formed cases per operation.
  function automatic lfrg_request_t random_request();
    lfrg_request_t req;
    int unsigned   sel;
    int            lo;
    req.op           = op_e'($urandom_range(3));
    req.first_value  = FieldW'($urandom());
    req.second_value = FieldW'($urandom());
    sel = $urandom_range(99);
    case (req.op)
      OP_RANGE: begin
        if (sel < 75) begin
          lo = int'($urandom_range(2000)) - 1000;
          req.first_value  = FieldW'(lo);
          req.second_value = FieldW'(lo + int'($urandom_range(300)));
        end else if (sel < 85) begin
          // Spans close to a power of two exercise the rejection loop.
          lo = -int'($urandom_range(64));
          req.first_value  = FieldW'(lo);
          req.second_value = FieldW'(lo + (1 << $urandom_range(22)) - int'($urandom_range(1)));
        end
      end
      OP_BITS: begin
        if (sel < 80) begin
          req.first_value = FieldW'(int'($urandom_range(34)) - 4);
        end
      end
      OP_FUZZY: begin
        if (sel < 60) begin
          req.first_value = FieldW'(int'($urandom_range(20)) - 5);
        end
      end
      default: begin
        if (sel < 80) begin
          req.first_value  = FieldW'($urandom_range(10));
          req.second_value = FieldW'($urandom_range(30));
        end else if (sel < 88) begin
          req.first_value  = FieldW'($urandom_range(8));
          req.second_value = FieldW'($urandom_range(8388607));
        end else if (sel < 93) begin
          req.first_value  = FieldW'(int'($urandom_range(300)) - 40);
          req.second_value = FieldW'($urandom_range(12));
        end else if (sel < 97) begin
          req.first_value  = FieldW'($urandom_range(20));
          req.second_value = FieldW'(-int'($urandom_range(100, 1)));
        end
      end
    endcase
    return req;
  endfunction

  function automatic void queue_request(input op_e op, input int first, input int second);
    lfrg_request_t req;
    req.op           = op;
    req.first_value  = FieldW'(first);
    req.second_value = FieldW'(second);
    pending_requests.push_back(req);
  endfunction

  // Driver: presents requests and the result-side ready at the falling edge.
  always @(negedge clk_i) begin
    lfrg_request_t req;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          in_valid_i     <= 1'b1;
          operation_i    <= req.op;
          first_value_i  <= req.first_value;
          second_value_i <= req.second_value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts accepted requests, checks accepted results, runs the watchdog.
  always @(posedge clk_i) begin
    logic [ValueW-1:0] want;
    if (rst_ni) begin
      req_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_values.push_back(predict_value(op_e'(operation_i), first_value_i,
                                                second_value_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_values.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MismatchShown) begin
            $display("unexpected result %0d with no request outstanding", value_o);
          end
        end else begin
          want = expected_values.pop_front();
          if (value_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= MismatchShown) begin
              $display("value mismatch: expected %0d, got %0d", $signed(want), value_o);
            end
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog expired after %0d cycles without a handshake", quiet_cycles);
        $display("tb_lagged_fibonacci_range_generator_core: done, errors");
        $finish;
      end
    end
  end

  // Sequencer: directed requests, then random segments under different seeds and idling.
  initial begin : sequencer
    logic [WordW-1:0] seeds [6];
    int unsigned      seg;
    int unsigned      k;

    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = WordW'($urandom());
    seeds[3] = WordW'(1);
    seeds[4] = WordW'($urandom());
    seeds[5] = WordW'($urandom());

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset seed.
    @(posedge clk_i);
    send_idle_pct = 24;
    recv_idle_pct = 72;
    queue_request(OP_RANGE, 0, 0);
    queue_request(OP_RANGE, 5, 5);
    queue_request(OP_RANGE, 10, 3);
    queue_request(OP_RANGE, -8388608, 8388607);
    queue_request(OP_RANGE, 0, 1);
    queue_request(OP_RANGE, -3, 4);
    queue_request(OP_RANGE, 0, 8);
    queue_request(OP_BITS, 0, 0);
    queue_request(OP_BITS, -5, 0);
    queue_request(OP_BITS, 24, 0);
    queue_request(OP_BITS, 8388607, -1);
    queue_request(OP_BITS, 1, 0);
    queue_request(OP_BITS, -8388608, 0);
    queue_request(OP_FUZZY, 1, 0);
    queue_request(OP_FUZZY, -8388608, 0);
    queue_request(OP_FUZZY, 8388607, 0);
    queue_request(OP_FUZZY, 0, 0);
    queue_request(OP_DICE, 3, 0);
    queue_request(OP_DICE, -7, 1);
    queue_request(OP_DICE, -4, 6);
    queue_request(OP_DICE, 300, 6);
    queue_request(OP_DICE, 5, -3);
    queue_request(OP_DICE, 255, 8388607);
    queue_request(OP_DICE, 8388607, 1);
    queue_request(OP_DICE, 2, 6);

    for (seg = 0; seg < 6; seg++) begin
      // Reseed only once everything in flight has been returned.
      while (pending_requests.size() != 0 || in_valid_i || expected_values.size() != 0) begin
        @(negedge clk_i);
      end
      repeat (8) @(negedge clk_i);
      seed_we_i  <= 1'b1;
      seed_i     <= seeds[seg];
      seed_value = seeds[seg];
      lag_built  = 1'b0;
      @(negedge clk_i);
      seed_we_i <= 1'b0;

      @(posedge clk_i);
      send_idle_pct = (seg < 2) ? 24 : (seg < 4) ? 72 : 0;
      recv_idle_pct = (seg < 2) ? 72 : (seg < 4) ? 24 : 0;
      for (k = 0; k < SegmentItems; k++) begin
        pending_requests.push_back(random_request());
      end
    end

    while (pending_requests.size() != 0 || in_valid_i || expected_values.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (30) @(negedge clk_i);
    if (mismatch_count == 0 && expected_values.size() == 0) begin
      $display("tb_lagged_fibonacci_range_generator_core: done, clean");
    end else begin
      $display("tb_lagged_fibonacci_range_generator_core: done, errors");
    end
    $finish;
  end

endmodule
